// File: rtl/core/drmag_pkg.sv
// shared types and constants for the dual-range accelerometer magnitude core
package drmag_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_GRAVITY_OFFSET = 2'd0;
  localparam logic [1:0] CFG_MIN_LEVEL      = 2'd1;
  localparam logic [1:0] CFG_SWITCH_LEVEL   = 2'd2;

  // configuration reset values
  localparam logic [11:0] GRAVITY_OFFSET_RST = 12'd2048;
  localparam logic [7:0]  MIN_LEVEL_RST      = 8'd4;
  localparam logic [7:0]  SWITCH_LEVEL_RST   = 8'd196;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // arithmetic constants
  localparam int          G2_SHIFT    = 22;          // 2048^2 counts per g^2
  localparam logic [6:0]  TENTHS_SQ   = 7'd100;      // tenths of g, squared
  localparam int          N_W         = 39;          // width of 100 * s
  localparam int          ROOT_W      = 20;          // width of isqrt(100 * s)
  localparam int          LOW_SHIFT   = 11;          // divide by 2048
  localparam logic [18:0] RECIP_41    = 19'd409201;  // ceil(2^24 / 41)
  localparam int          RECIP_SHIFT = 24;

  // configuration register set
  typedef struct packed {
    logic [11:0] gravity_offset;
    logic [7:0]  min_level_g2;
    logic [7:0]  switch_level_g2;
  } cfg_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic [N_W-1:0] n;    // 100 times the selected squared magnitude, 0 below minimum
    logic           hi;   // high-range sensor selected
  } item_t;

  // queue status seen by the top level
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// File: rtl/core/drmag_front.sv
// front: squares, range classification and scaling by 100
module drmag_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  drmag_pkg::cfg_t      cfg,
  input  logic signed [15:0]   low_x,
  input  logic signed [15:0]   low_y,
  input  logic signed [15:0]   low_z,
  input  logic signed [15:0]   high_x,
  input  logic signed [15:0]   high_y,
  input  logic signed [15:0]   high_z,
  output logic                 push,
  output drmag_pkg::item_t     item
);

  logic signed [16:0] lz_adj;
  logic signed [31:0] p_lx, p_ly, p_hx, p_hy, p_hz;
  logic signed [33:0] p_lz;

  logic        sq_valid;
  logic [30:0] sq_lx, sq_ly, sq_lz, sq_hx, sq_hy, sq_hz;

  logic [31:0] s, s2, min_th, sw_th;
  logic        sel_hi_next;
  logic [31:0] sel_next;

  logic        sel_valid;
  logic [31:0] sel;
  logic        sel_hi;

  // gravity offset removal and the six squares
  always_comb begin
    lz_adj = 17'(low_z) - $signed({5'b0, cfg.gravity_offset});
    p_lx = low_x * low_x;
    p_ly = low_y * low_y;
    p_lz = lz_adj * lz_adj;
    p_hx = high_x * high_x;
    p_hy = high_y * high_y;
    p_hz = high_z * high_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    sq_lx <= p_lx[30:0];
    sq_ly <= p_ly[30:0];
    sq_lz <= p_lz[30:0];
    sq_hx <= p_hx[30:0];
    sq_hy <= p_hy[30:0];
    sq_hz <= p_hz[30:0];
  end

  // sums and range classification, switch test first
  always_comb begin
    s      = {1'b0, sq_lx} + {1'b0, sq_ly} + {1'b0, sq_lz};
    s2     = {1'b0, sq_hx} + {1'b0, sq_hy} + {1'b0, sq_hz};
    min_th = {2'b0, cfg.min_level_g2, 22'b0};
    sw_th  = {2'b0, cfg.switch_level_g2, 22'b0};
    sel_hi_next = (s >= sw_th);
    if (sel_hi_next) begin
      sel_next = s2;
    end else if (s >= min_th) begin
      sel_next = s;
    end else begin
      sel_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else begin
      sel_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    sel    <= sel_next;
    sel_hi <= sel_hi_next;
  end

  // scale to tenths squared
  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    item.n  <= sel * drmag_pkg::TENTHS_SQ;
    item.hi <= sel_hi;
  end

endmodule

// File: rtl/core/drmag_queue.sv
// short fifo between front and back
module drmag_queue #(
  parameter int DEPTH = drmag_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  drmag_pkg::item_t         wr_item,
  input  logic                     pop,
  output drmag_pkg::item_t         rd_item,
  output drmag_pkg::queue_status_t status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  drmag_pkg::item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(DEPTH));
  assign do_pop  = pop && !status.empty;
  assign do_push = push && (!status.full || do_pop);
  assign rd_item = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  // no transfer is dropped on a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!status.full || do_pop))
    else $error("queue overflow");
`endif

endmodule

// File: rtl/core/drmag_back.sv
// back: pipelined integer square root and scaling to tenths of g
module drmag_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  drmag_pkg::item_t  in_item,
  output logic              done,
  output logic [11:0]       magnitude_tenths,
  output logic              used_high_range
);

  localparam int ROOT_W = drmag_pkg::ROOT_W;
  localparam int NX_W   = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  logic [ROOT_W:0]    vld;
  logic [NX_W-1:0]    nv   [ROOT_W+1];
  logic [REM_W-1:0]   rem  [ROOT_W+1];
  logic [ROOT_W-1:0]  root [ROOT_W+1];
  logic               hi   [ROOT_W+1];

  // stage zero takes the item from the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    nv[0]   <= NX_W'(in_item.n);
    rem[0]  <= '0;
    root[0] <= '0;
    hi[0]   <= in_item.hi;
  end

  // one root bit per stage, restoring digit recurrence
  for (genvar g = 1; g <= ROOT_W; g++) begin : g_sqrt
    logic [REM_W+1:0] acc, trial;
    logic             ge;

    always_comb begin
      acc   = {rem[g-1], nv[g-1][NX_W-1:NX_W-2]};
      trial = {2'b00, root[g-1], 2'b01};
      ge    = (acc >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= vld[g-1];
      end
    end

    always_ff @(posedge clk) begin
      nv[g]   <= {nv[g-1][NX_W-3:0], 2'b00};
      rem[g]  <= ge ? REM_W'(acc - trial) : acc[REM_W-1:0];
      root[g] <= {root[g-1][ROOT_W-2:0], ge};
      hi[g]   <= hi[g-1];
    end
  end

  // divide: shift for the low range, reciprocal multiply for 164 = 4 * 41
  logic        div_valid;
  logic [36:0] div_prod;
  logic [8:0]  div_low;
  logic        div_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid <= 1'b0;
    end else begin
      div_valid <= vld[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    div_prod <= root[ROOT_W][ROOT_W-1:2] * drmag_pkg::RECIP_41;
    div_low  <= root[ROOT_W][ROOT_W-1:drmag_pkg::LOW_SHIFT];
    div_hi   <= hi[ROOT_W];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    magnitude_tenths <= div_hi ? div_prod[drmag_pkg::RECIP_SHIFT+11:drmag_pkg::RECIP_SHIFT]
                               : {3'b000, div_low};
    used_high_range  <= div_hi;
  end

endmodule

// File: rtl/core/dual_range_accel_magnitude_core.sv
// top level: magnitude in tenths of g from a low-range and a high-range accelerometer
// path to done: front registers, queue, square root stages, divide register, result register
// throughput: one sample per cycle, set by the square root pipeline (one root bit a stage)
// busy stays low: the back end drains the queue every cycle and the receiver cannot stall
// reset: synchronous, clears all valid flags and the queue, loads configuration defaults
// configuration writes are taken every cycle (cfg_ready is always high)
module dual_range_accel_magnitude_core #(
  parameter int QUEUE_DEPTH = drmag_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] low_x,
  input  logic signed [15:0] low_y,
  input  logic signed [15:0] low_z,
  input  logic signed [15:0] high_x,
  input  logic signed [15:0] high_y,
  input  logic signed [15:0] high_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  output logic               done,
  output logic [11:0]        magnitude_tenths,
  output logic               used_high_range
);

  drmag_pkg::cfg_t          cfg;
  drmag_pkg::item_t         f_item, q_item;
  drmag_pkg::queue_status_t q_status;
  logic                     f_push;
  logic                     accept;

  assign cfg_ready = 1'b1;
  assign busy      = q_status.full;
  assign accept    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity_offset  <= drmag_pkg::GRAVITY_OFFSET_RST;
      cfg.min_level_g2    <= drmag_pkg::MIN_LEVEL_RST;
      cfg.switch_level_g2 <= drmag_pkg::SWITCH_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        drmag_pkg::CFG_GRAVITY_OFFSET: cfg.gravity_offset  <= cfg_data;
        drmag_pkg::CFG_MIN_LEVEL:      cfg.min_level_g2    <= cfg_data[7:0];
        drmag_pkg::CFG_SWITCH_LEVEL:   cfg.switch_level_g2 <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  drmag_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cfg    (cfg),
    .low_x  (low_x),
    .low_y  (low_y),
    .low_z  (low_z),
    .high_x (high_x),
    .high_y (high_y),
    .high_z (high_z),
    .push   (f_push),
    .item   (f_item)
  );

  drmag_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (f_push),
    .wr_item (f_item),
    .pop     (!q_status.empty),
    .rd_item (q_item),
    .status  (q_status)
  );

  drmag_back u_back (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (!q_status.empty),
    .in_item          (q_item),
    .done             (done),
    .magnitude_tenths (magnitude_tenths),
    .used_high_range  (used_high_range)
  );

`ifndef SYNTH
  // queue drains every cycle, so it never fills
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("queue filled up");

  // low range is only used below 255 g^2, so its result stays under 16 g
  a_low_bound: assert property (@(posedge clk) disable iff (rst)
    (done && !used_high_range) |-> (magnitude_tenths < 12'd160))
    else $error("low-range magnitude out of range");

  // high range result bounded by full-scale on all three axes
  a_high_bound: assert property (@(posedge clk) disable iff (rst)
    (done && used_high_range) |-> (magnitude_tenths <= 12'd3460))
    else $error("high-range magnitude out of range");
`endif

endmodule
